/* design/rpa_pkg.sv */
// Shared types, field widths and codes of the rank placement allocator.
// No dependencies; every other design file but rpa_ram imports this package.
`default_nettype none
package rpa_pkg;

    localparam int MAX_NODES_DEF = 64;

    localparam int KIND_W  = 2;
    localparam int IDX_W   = 6;
    localparam int ID_W    = 16;
    localparam int CORE_W  = 10;
    localparam int ACT_W   = 16;
    localparam int RANK_W  = 16;
    localparam int USED_W  = 7;
    localparam int STAT_W  = 2;
    localparam int PLACE_W = 26;
    localparam int ENTRY_W = ID_W + CORE_W + ACT_W;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REQ   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    localparam logic [STAT_W-1:0] ST_PLACED = 2'd0;
    localparam logic [STAT_W-1:0] ST_DONE   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOCAP  = 2'd2;

    typedef struct packed {
        logic load_in;
        logic do_write;
        logic do_begin;
        logic rd_scan;
        logic div_start;
        logic lvl_update;
        logic scan_next;
        logic scan_clear;
        logic mul_load;
        logic spare_update;
        logic lvl_commit;
        logic snap;
        logic wrap;
        logic rd_cursor;
        logic place;
        logic advance;
        logic res_exhausted;
        logic res_fail;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              all_placed;
        logic              len_zero;
        logic              scan_last;
        logic              iter_done;
        logic              cur_end;
        logic              core_zero;
        logic              div_done;
        logic              fits;
        logic              out_busy;
    } t_stat;

endpackage
`default_nettype wire

/* design/rpa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* design/rpa_div.sv */
// Restoring divider, one quotient bit per cycle: active count over core count.
// Depends on rpa_pkg for the field widths.
`default_nettype none
module rpa_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [rpa_pkg::ACT_W-1:0]  i_dividend,
    input  wire logic [rpa_pkg::CORE_W-1:0] i_divisor,
    output logic                           o_done,
    output logic      [rpa_pkg::ACT_W-1:0]  o_quot,
    output logic                           o_rem_nz
);
    import rpa_pkg::*;

    localparam int CW = $clog2(ACT_W);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [ACT_W-1:0]  r_quo;
    logic [CORE_W-1:0] r_rem;
    logic [CORE_W-1:0] r_den;

    logic [CORE_W:0]   w_trial;
    logic              w_ge;
    logic [CORE_W-1:0] w_rem;

    // The partial remainder stays below the divisor, so the difference fits.
    always_comb begin
        w_trial = {r_rem, r_quo[ACT_W-1]};
        w_ge    = w_trial >= {1'b0, r_den};
        w_rem   = w_ge ? CORE_W'(w_trial - {1'b0, r_den}) : CORE_W'(w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(ACT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[ACT_W-2:0], w_ge};
            r_rem <= w_rem;
        end
    end

    assign o_done   = r_done;
    assign o_quot   = r_quo;
    assign o_rem_nz = r_rem != '0;
endmodule
`default_nettype wire

/* design/rpa_ctrl.sv */
// Controller state machine of the rank placement allocator.
// Depends on rpa_pkg for the command and status structs and the codes.
`default_nettype none
module rpa_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire rpa_pkg::t_stat i_stat,
    output rpa_pkg::t_cmd       o_cmd
);
    import rpa_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_L1_RD   = 4'd2;
    localparam logic [3:0] S_L1_DIV  = 4'd3;
    localparam logic [3:0] S_L1_WAIT = 4'd4;
    localparam logic [3:0] S_L2_RD   = 4'd5;
    localparam logic [3:0] S_L2_MUL  = 4'd6;
    localparam logic [3:0] S_L2_CMP  = 4'd7;
    localparam logic [3:0] S_L_END   = 4'd8;
    localparam logic [3:0] S_R_CHECK = 4'd9;
    localparam logic [3:0] S_R_MUL   = 4'd10;
    localparam logic [3:0] S_R_CMP   = 4'd11;
    localparam logic [3:0] S_PUSH    = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.kind)
                    KIND_WRITE: begin
                        o_cmd.do_write = 1'b1;
                        n_state        = S_IDLE;
                    end
                    KIND_BEGIN: begin
                        o_cmd.do_begin = 1'b1;
                        n_state        = S_L1_RD;
                    end
                    KIND_REQ: begin
                        if (i_stat.all_placed) begin
                            o_cmd.res_exhausted = 1'b1;
                            n_state             = S_PUSH;
                        end else begin
                            o_cmd.snap = 1'b1;
                            n_state    = S_R_CHECK;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_L1_RD: begin
                if (i_stat.len_zero) begin
                    n_state = S_L_END;
                end else begin
                    o_cmd.rd_scan = 1'b1;
                    n_state       = S_L1_DIV;
                end
            end
            S_L1_DIV: begin
                if (i_stat.core_zero) begin
                    if (i_stat.scan_last) begin
                        o_cmd.scan_clear = 1'b1;
                        n_state          = S_L2_RD;
                    end else begin
                        o_cmd.scan_next = 1'b1;
                        n_state         = S_L1_RD;
                    end
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_L1_WAIT;
                end
            end
            S_L1_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.lvl_update = 1'b1;
                    if (i_stat.scan_last) begin
                        o_cmd.scan_clear = 1'b1;
                        n_state          = S_L2_RD;
                    end else begin
                        o_cmd.scan_next = 1'b1;
                        n_state         = S_L1_RD;
                    end
                end
            end
            S_L2_RD: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = S_L2_MUL;
            end
            S_L2_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state        = S_L2_CMP;
            end
            S_L2_CMP: begin
                o_cmd.spare_update = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_L_END;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_L2_RD;
                end
            end
            S_L_END: begin
                o_cmd.lvl_commit = 1'b1;
                n_state          = S_IDLE;
            end
            S_R_CHECK: begin
                // An empty table or a search that used up its step budget
                // ends with the cursor state restored.
                if (i_stat.len_zero || i_stat.iter_done) begin
                    o_cmd.res_fail = 1'b1;
                    n_state        = S_PUSH;
                end else if (i_stat.cur_end) begin
                    o_cmd.wrap = 1'b1;
                end else begin
                    o_cmd.rd_cursor = 1'b1;
                    n_state         = S_R_MUL;
                end
            end
            S_R_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state        = S_R_CMP;
            end
            S_R_CMP: begin
                if (i_stat.fits) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_PUSH;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_R_CHECK;
                end
            end
            S_PUSH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* design/rpa_dp.sv */
// Datapath of the rank placement allocator: node table, placement state,
// multiplier, divider and output register. Depends on rpa_pkg, rpa_ram, rpa_div.
`default_nettype none
module rpa_dp #(
    parameter int MAX_NODES = rpa_pkg::MAX_NODES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire rpa_pkg::t_cmd              i_cmd,
    output rpa_pkg::t_stat                  o_stat,
    input  wire logic [rpa_pkg::KIND_W-1:0] i_kind,
    input  wire logic [rpa_pkg::IDX_W-1:0]  i_node_index,
    input  wire logic [rpa_pkg::ID_W-1:0]   i_node_ident,
    input  wire logic [rpa_pkg::CORE_W-1:0] i_cores,
    input  wire logic [rpa_pkg::ACT_W-1:0]  i_active_count,
    input  wire logic [rpa_pkg::RANK_W-1:0] i_ranks_wanted,
    input  wire logic [rpa_pkg::USED_W-1:0] i_nodes_used,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic      [rpa_pkg::ID_W-1:0]   o_placed_node,
    output logic      [rpa_pkg::RANK_W-1:0] o_rank_index,
    output logic                            o_last,
    output logic      [rpa_pkg::STAT_W-1:0] o_status
);
    import rpa_pkg::*;

    localparam int AW = MAX_NODES > 1 ? $clog2(MAX_NODES) : 1;
    localparam int LW = $clog2(MAX_NODES + 1);
    localparam int IW = $clog2(2 * MAX_NODES + 3);

    // Latched input beat.
    logic [KIND_W-1:0] r_in_kind;
    logic [IDX_W-1:0]  r_in_idx;
    logic [ID_W-1:0]   r_in_ident;
    logic [CORE_W-1:0] r_in_cores;
    logic [ACT_W-1:0]  r_in_act;
    logic [RANK_W-1:0] r_in_wanted;
    logic [USED_W-1:0] r_in_used;

    // Placement state.
    logic [LW-1:0]      r_len;
    logic [ACT_W-1:0]   r_level;
    logic               r_filler;
    logic [LW-1:0]      r_cursor;
    logic [PLACE_W-1:0] r_placed;
    logic [RANK_W-1:0]  r_next;
    logic [RANK_W-1:0]  r_target;
    logic [LW-1:0]      r_scan;
    logic               r_spare;
    logic [IW-1:0]      r_iter;
    logic [LW-1:0]      r_snap_cursor;
    logic [PLACE_W-1:0] r_snap_placed;
    logic               r_snap_filler;
    logic [PLACE_W-1:0] r_prod;

    logic [ID_W-1:0]    r_res_node;
    logic [RANK_W-1:0]  r_res_rank;
    logic               r_res_last;
    logic [STAT_W-1:0]  r_res_status;

    logic               r_o_valid;
    logic [ID_W-1:0]    r_o_node;
    logic [RANK_W-1:0]  r_o_rank;
    logic               r_o_last;
    logic [STAT_W-1:0]  r_o_status;

    logic [ENTRY_W-1:0] w_rd;
    logic [ID_W-1:0]    w_rd_id;
    logic [CORE_W-1:0]  w_rd_cores;
    logic [ACT_W-1:0]   w_rd_act;
    logic               w_we;
    logic               w_re;
    logic [AW-1:0]      w_raddr;
    logic [LW-1:0]      w_len_sat;
    logic               w_div_done;
    logic [ACT_W-1:0]   w_div_quot;
    logic               w_div_rem_nz;
    logic [ACT_W-1:0]   w_ceil;
    logic               w_fits;

    assign w_rd_id    = w_rd[ENTRY_W-1 -: ID_W];
    assign w_rd_cores = w_rd[ACT_W +: CORE_W];
    assign w_rd_act   = w_rd[ACT_W-1:0];

    assign w_we    = i_cmd.do_write && (32'(r_in_idx) < MAX_NODES);
    assign w_re    = i_cmd.rd_scan || i_cmd.rd_cursor;
    assign w_raddr = i_cmd.rd_scan ? r_scan[AW-1:0] : r_cursor[AW-1:0];

    assign w_len_sat = (32'(r_in_used) > MAX_NODES) ? LW'(MAX_NODES) : LW'(r_in_used);

    // The rounded-up quotient cannot overflow: a divisor of one leaves no remainder.
    assign w_ceil = w_div_quot + ACT_W'(w_div_rem_nz);

    // In the filler round the quota is cores*level - active; comparing
    // placed + active against the product avoids the clamped subtraction.
    assign w_fits = r_filler ? ((27'(r_placed) + 27'(w_rd_act)) < 27'(r_prod))
                             : (r_placed < PLACE_W'(w_rd_cores));

    rpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_NODES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(r_in_idx)),
        .i_wdata ({r_in_ident, r_in_cores, r_in_act}),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    rpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_rd_act),
        .i_divisor  (w_rd_cores),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem_nz   (w_div_rem_nz)
    );

    always_comb begin
        o_stat.kind       = r_in_kind;
        o_stat.all_placed = r_next >= r_target;
        o_stat.len_zero   = r_len == '0;
        o_stat.scan_last  = (r_scan + LW'(1)) == r_len;
        o_stat.iter_done  = r_iter == IW'(2 * 32'(r_len) + 2);
        o_stat.cur_end    = r_cursor >= r_len;
        o_stat.core_zero  = w_rd_cores == '0;
        o_stat.div_done   = w_div_done;
        o_stat.fits       = w_fits;
        o_stat.out_busy   = r_o_valid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_kind   <= i_kind;
            r_in_idx    <= i_node_index;
            r_in_ident  <= i_node_ident;
            r_in_cores  <= i_cores;
            r_in_act    <= i_active_count;
            r_in_wanted <= i_ranks_wanted;
            r_in_used   <= i_nodes_used;
        end
        if (i_cmd.mul_load) begin
            r_prod <= PLACE_W'(w_rd_cores) * PLACE_W'(r_level);
        end
        if (i_cmd.snap) begin
            r_snap_cursor <= r_cursor;
            r_snap_placed <= r_placed;
            r_snap_filler <= r_filler;
        end
        if (i_cmd.res_exhausted) begin
            r_res_node   <= '0;
            r_res_rank   <= '0;
            r_res_last   <= 1'b0;
            r_res_status <= ST_DONE;
        end else if (i_cmd.res_fail) begin
            r_res_node   <= '0;
            r_res_rank   <= '0;
            r_res_last   <= 1'b0;
            r_res_status <= ST_NOCAP;
        end else if (i_cmd.place) begin
            r_res_node   <= w_rd_id;
            r_res_rank   <= r_next;
            r_res_last   <= (r_next + RANK_W'(1)) == r_target;
            r_res_status <= ST_PLACED;
        end
        if (i_cmd.out_load) begin
            r_o_node   <= r_res_node;
            r_o_rank   <= r_res_rank;
            r_o_last   <= r_res_last;
            r_o_status <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_level   <= '0;
            r_filler  <= 1'b0;
            r_cursor  <= '0;
            r_placed  <= '0;
            r_next    <= '0;
            r_target  <= '0;
            r_scan    <= '0;
            r_spare   <= 1'b0;
            r_iter    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.do_begin) begin
                r_len    <= w_len_sat;
                r_target <= r_in_wanted;
                r_next   <= '0;
                r_cursor <= '0;
                r_placed <= '0;
                r_level  <= '0;
                r_filler <= 1'b0;
                r_scan   <= '0;
                r_spare  <= 1'b0;
            end
            if (i_cmd.lvl_update && (w_ceil > r_level)) begin
                r_level <= w_ceil;
            end
            if (i_cmd.scan_next) begin
                r_scan <= r_scan + LW'(1);
            end
            if (i_cmd.scan_clear) begin
                r_scan <= '0;
            end
            if (i_cmd.spare_update && (r_prod > PLACE_W'(w_rd_act))) begin
                r_spare <= 1'b1;
            end
            // Spare room implies a nonzero level, so the filler round follows it.
            if (i_cmd.lvl_commit) begin
                if (!r_spare) begin
                    r_level <= '0;
                end
                r_filler <= r_spare;
            end
            if (i_cmd.snap) begin
                r_iter <= '0;
            end
            if (i_cmd.wrap) begin
                r_filler <= 1'b0;
                r_cursor <= '0;
                r_placed <= '0;
                r_iter   <= r_iter + IW'(1);
            end
            if (i_cmd.advance) begin
                r_cursor <= r_cursor + LW'(1);
                r_placed <= '0;
                r_iter   <= r_iter + IW'(1);
            end
            if (i_cmd.place) begin
                r_placed <= r_placed + PLACE_W'(1);
                r_next   <= r_next + RANK_W'(1);
            end
            if (i_cmd.res_fail) begin
                r_cursor <= r_snap_cursor;
                r_placed <= r_snap_placed;
                r_filler <= r_snap_filler;
            end
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_placed_node = r_o_node;
    assign o_rank_index  = r_o_rank;
    assign o_last        = r_o_last;
    assign o_status      = r_o_status;
endmodule
`default_nettype wire

/* design/rank_placement_allocator_top.sv */
// Top level of the rank placement allocator: controller plus datapath.
// Depends on rpa_pkg, rpa_ctrl and rpa_dp (which holds rpa_ram and rpa_div).
//
// One item is handled at a time. A request beat places a rank on the node
// under the cursor when it still has quota and passes over every node that
// has none, wrapping the cursor at the end of the table; a request past the
// last wanted rank ends without a search. A begin beat walks the node table
// twice through the single read port: in the first pass the bit-serial
// divider finds the rounded-up active/cores ratio of each node with nonzero
// cores, and the second pass is the spare-room check. A result sits in an
// output register, and the next beat is accepted while it waits; only a
// further result stalls.
`default_nettype none
module rank_placement_allocator_top #(
    parameter int MAX_NODES = rpa_pkg::MAX_NODES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [rpa_pkg::KIND_W-1:0] i_kind,
    input  wire logic [rpa_pkg::IDX_W-1:0]  i_node_index,
    input  wire logic [rpa_pkg::ID_W-1:0]   i_node_ident,
    input  wire logic [rpa_pkg::CORE_W-1:0] i_cores,
    input  wire logic [rpa_pkg::ACT_W-1:0]  i_active_count,
    input  wire logic [rpa_pkg::RANK_W-1:0] i_ranks_wanted,
    input  wire logic [rpa_pkg::USED_W-1:0] i_nodes_used,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic      [rpa_pkg::ID_W-1:0]   o_placed_node,
    output logic      [rpa_pkg::RANK_W-1:0] o_rank_index,
    output logic                            o_last,
    output logic      [rpa_pkg::STAT_W-1:0] o_status
);
    import rpa_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    rpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rpa_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_kind         (i_kind),
        .i_node_index   (i_node_index),
        .i_node_ident   (i_node_ident),
        .i_cores        (i_cores),
        .i_active_count (i_active_count),
        .i_ranks_wanted (i_ranks_wanted),
        .i_nodes_used   (i_nodes_used),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_placed_node  (o_placed_node),
        .o_rank_index   (o_rank_index),
        .o_last         (o_last),
        .o_status       (o_status)
    );
endmodule
`default_nettype wire
